FILE: sv/sreh_pkg.sv
// Shared types and constants for the segment/rectangle edge hit block.
`default_nettype none
package sreh_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int DET_W      = 2 * COORD_BITS + 3;
  localparam int MAG_W      = DET_W - 1;
  localparam int QDEPTH     = 8;
  localparam int QAW        = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_BOTTOM = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic [FRAC_BITS:0]   position;
    logic [1:0]           edge_index;
    logic [7:0]           side_code;
  } out_item_t;

  typedef struct packed {
    logic                 hit;
    logic                 eq;
    logic [MAG_W-1:0]     num;
    logic [MAG_W-1:0]     den;
    logic [FRAC_BITS-1:0] quo;
    logic [1:0]           edge_index;
    logic [7:0]           side_code;
  } div_item_t;

endpackage
`default_nettype wire

FILE: sv/sreh_front.sv
// Front end: register segments, form edge determinants, pick the first edge hit.
`default_nettype none
module sreh_front
  import sreh_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         acc,
  input  wire in_item_t                     item,
  input  wire logic signed [COORD_BITS-1:0] rl,
  input  wire logic signed [COORD_BITS-1:0] rt,
  input  wire logic signed [COORD_BITS-1:0] rr,
  input  wire logic signed [COORD_BITS-1:0] rb,
  input  wire logic [QAW:0]                 q_cnt,
  output logic                              full,
  output logic                              push,
  output div_item_t                         push_item
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;

  logic      v0_r, v1_r, v2_r;
  in_item_t  s0_r;
  logic signed [PW-1:0] p_r [4][6];
  logic signed [PW-1:0] p_nxt [4][6];
  logic [1:0] code_r, code_nxt;
  div_item_t  s2_r, s2_nxt;

  logic [QAW+1:0] occ;
  assign occ  = (QAW+2)'(q_cnt) + (QAW+2)'(v0_r) + (QAW+2)'(v1_r) + (QAW+2)'(v2_r);
  assign full = (occ >= (QAW+2)'(QDEPTH));
  assign push = v2_r;
  assign push_item = s2_r;

  always_comb begin
    logic signed [DW-1:0] sx, sy, ex, ey, dx, dy;
    logic signed [DW-1:0] ea [4];
    logic signed [DW-1:0] eb [4];
    logic signed [DW-1:0] ec [4];
    logic signed [DW-1:0] ee [4];
    logic signed [DW-1:0] be, ac, ax, by;
    logic start_in;
    sx = DW'(s0_r.start_x);
    sy = DW'(s0_r.start_y);
    ex = DW'(s0_r.end_x);
    ey = DW'(s0_r.end_y);
    dx = ex - sx;
    dy = ey - sy;
    ea[0] = DW'(rl); eb[0] = DW'(rt); ec[0] = DW'(rr); ee[0] = DW'(rt);
    ea[1] = DW'(rr); eb[1] = DW'(rt); ec[1] = DW'(rr); ee[1] = DW'(rb);
    ea[2] = DW'(rl); eb[2] = DW'(rb); ec[2] = DW'(rr); ee[2] = DW'(rb);
    ea[3] = DW'(rl); eb[3] = DW'(rt); ec[3] = DW'(rl); ee[3] = DW'(rb);
    for (int i = 0; i < 4; i++) begin
      be = eb[i] - ee[i];
      ac = ea[i] - ec[i];
      ax = ea[i] - sx;
      by = eb[i] - sy;
      p_nxt[i][0] = PW'(dx) * PW'(be);
      p_nxt[i][1] = PW'(ac) * PW'(dy);
      p_nxt[i][2] = PW'(ax) * PW'(be);
      p_nxt[i][3] = PW'(ac) * PW'(by);
      p_nxt[i][4] = PW'(dx) * PW'(by);
      p_nxt[i][5] = PW'(ax) * PW'(dy);
    end
    start_in = (rl < s0_r.start_x) && (s0_r.start_x < rr) &&
               (rt < s0_r.start_y) && (s0_r.start_y < rb);
    if (start_in) begin
      code_nxt = {(s0_r.end_x < s0_r.start_x), (s0_r.end_y > s0_r.start_y)};
    end else begin
      code_nxt = {(s0_r.end_x > s0_r.start_x), (s0_r.end_y < s0_r.start_y)};
    end
  end

  // Solve each edge, normalize the sign of d, keep the lowest edge that counts.
  always_comb begin
    logic signed [DET_W-1:0] d, un, vn;
    logic ok;
    s2_nxt = '0;
    for (int i = 3; i >= 0; i--) begin
      d  = DET_W'(p_r[i][0]) - DET_W'(p_r[i][1]);
      un = DET_W'(p_r[i][2]) - DET_W'(p_r[i][3]);
      vn = DET_W'(p_r[i][4]) - DET_W'(p_r[i][5]);
      if (d < 0) begin
        d  = -d;
        un = -un;
        vn = -vn;
      end
      ok = (d != 0) && (un >= 0) && (un <= d) && (vn >= 0) && (vn <= d);
      if (ok) begin
        s2_nxt.hit        = 1'b1;
        s2_nxt.eq         = (un == d);
        s2_nxt.num        = MAG_W'(un);
        s2_nxt.den        = MAG_W'(d);
        s2_nxt.edge_index = 2'(i);
        s2_nxt.side_code  = i[0] ? {6'd0, code_r} : ~{6'd0, code_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= acc;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
    if (acc) s0_r <= item;
    p_r    <= p_nxt;
    code_r <= code_nxt;
    s2_r   <= s2_nxt;
  end

endmodule
`default_nettype wire

FILE: sv/sreh_back.sv
// Back end: decoupling queue, pipelined fraction divider and result register.
`default_nettype none
module sreh_back
  import sreh_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire div_item_t  push_item,
  output logic [QAW:0]    q_cnt,
  input  wire logic       pop,
  output logic            empty,
  output out_item_t       res
);

  div_item_t       mem_r [QDEPTH];
  logic [QAW-1:0]  wp_r, rp_r;
  logic [QAW:0]    cnt_r;
  logic            q_pop, adv;

  logic            sv_r [FRAC_BITS+1];
  div_item_t       st_r [FRAC_BITS+1];
  div_item_t       st_nxt [FRAC_BITS+1];
  logic            ov_r;
  out_item_t       out_r;

  assign q_cnt = cnt_r;
  assign empty = !ov_r;
  assign res   = out_r;
  assign adv   = !ov_r || pop;
  assign q_pop = adv && (cnt_r != '0);

  // One restoring step per stage: n <- 2n - d when that stays non-negative.
  always_comb begin
    logic [MAG_W:0] n2;
    st_nxt[0] = mem_r[rp_r];
    for (int k = 1; k <= FRAC_BITS; k++) begin
      st_nxt[k] = st_r[k-1];
      n2 = {st_r[k-1].num, 1'b0};
      st_nxt[k].quo = {st_r[k-1].quo[FRAC_BITS-2:0], 1'b0};
      if (n2 >= {1'b0, st_r[k-1].den}) begin
        st_nxt[k].num    = MAG_W'(n2 - {1'b0, st_r[k-1].den});
        st_nxt[k].quo[0] = 1'b1;
      end else begin
        st_nxt[k].num = MAG_W'(n2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      ov_r  <= 1'b0;
      for (int k = 0; k <= FRAC_BITS; k++) sv_r[k] <= 1'b0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(q_pop);
      if (adv) begin
        sv_r[0] <= q_pop;
        for (int k = 1; k <= FRAC_BITS; k++) sv_r[k] <= sv_r[k-1];
        ov_r <= sv_r[FRAC_BITS];
      end
    end
    if (push) mem_r[wp_r] <= push_item;
    if (adv) begin
      st_r <= st_nxt;
      out_r.hit        <= st_r[FRAC_BITS].hit;
      out_r.edge_index <= st_r[FRAC_BITS].edge_index;
      out_r.side_code  <= st_r[FRAC_BITS].side_code;
      if (!st_r[FRAC_BITS].hit) begin
        out_r.position <= '0;
      end else if (st_r[FRAC_BITS].eq) begin
        out_r.position <= {1'b1, {FRAC_BITS{1'b0}}};
      end else begin
        out_r.position <= {1'b0, st_r[FRAC_BITS].quo};
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/segment_rectangle_edge_hit.sv
// Top level: segment crossing against the top, right, bottom and left edges of a configured rectangle.
// Path from push to a visible result: the front registers, the queue,
// the divider stage registers and the result register.
// Throughput: one segment per cycle unless in_full or an unpopped result stalls.
// Reset (rst_n low, synchronous): rectangle goes to (0,0)-(100,50), all
// in-flight segments and queued results are dropped.
`default_nettype none
module segment_rectangle_edge_hit
  import sreh_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_push,
  output logic                        in_full,
  input  wire in_item_t               in_item,
  output logic                        out_empty,
  input  wire logic                   out_pop,
  output out_item_t                   out_item,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [COORD_BITS-1:0]  cfg_data
);

  logic signed [COORD_BITS-1:0] rl_r, rt_r, rr_r, rb_r;
  logic        acc;
  logic        f_push;
  div_item_t   f_item;
  logic [QAW:0] q_cnt;

  // Register writes are always taken in one transfer.
  assign cfg_ready = 1'b1;
  assign acc       = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rl_r <= COORD_BITS'(0);
      rt_r <= COORD_BITS'(0);
      rr_r <= COORD_BITS'(100);
      rb_r <= COORD_BITS'(50);
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LEFT:   rl_r <= cfg_data;
        REG_TOP:    rt_r <= cfg_data;
        REG_RIGHT:  rr_r <= cfg_data;
        REG_BOTTOM: rb_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Front: solves the top, right, bottom and left edges in parallel and picks the lowest-numbered one that counts.
  sreh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .item      (in_item),
    .rl        (rl_r),
    .rt        (rt_r),
    .rr        (rr_r),
    .rb        (rb_r),
    .q_cnt     (q_cnt),
    .full      (in_full),
    .push      (f_push),
    .push_item (f_item)
  );

  // Back: queue plus fraction divider; stalls only on the result side.
  sreh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_item (f_item),
    .q_cnt     (q_cnt),
    .pop       (out_pop),
    .empty     (out_empty),
    .res       (out_item)
  );

endmodule
`default_nettype wire
